// ===== rtl/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared widths, types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int EXP_WIDTH = 63;
  localparam int MOD_WIDTH = 31;
  localparam int CNT_WIDTH = $clog2(MOD_WIDTH + 1);

  typedef logic [MOD_WIDTH-1:0] mod_t;
  typedef logic [EXP_WIDTH-1:0] exp_t;
  typedef logic [CNT_WIDTH-1:0] cnt_t;

  localparam mod_t MODULUS_RESET = MOD_WIDTH'(998244353);

endpackage

// ===== rtl/modular_exponentiation_top.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Right-to-left square and multiply: base ** exponent mod a configured modulus.
// ----------------------------------------------------------------------------
//  channel   signals                       direction  beat taken when
//  command   start, base_i, exponent_i     in         start && !busy
//  result    valid_o, power_mod_o          out        valid_o (one cycle)
//  config    cfg_we_i, cfg_wdata_i         in         cfg_we_i
//
//  the base is reduced in one pass of the bit-serial multipliers, then each
//  exponent bit up to the highest set one takes one pass (multiply and square
//  run side by side). reset loads the modulus with its default value.
//  results cannot be stalled; a new command may start in the result cycle.
// ----------------------------------------------------------------------------
module modular_exponentiation_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [modexp_pkg::MOD_WIDTH-1:0]     base_i,
  input  logic [modexp_pkg::EXP_WIDTH-1:0]     exponent_i,
  output logic                                 valid_o,
  output logic [modexp_pkg::MOD_WIDTH-1:0]     power_mod_o,
  input  logic                                 cfg_we_i,
  input  logic [modexp_pkg::MOD_WIDTH-1:0]     cfg_wdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RED,
    S_ROUND
  } state_e;

  state_e           state_q;
  modexp_pkg::mod_t modulus_q;
  modexp_pkg::mod_t base_q;
  modexp_pkg::mod_t acc_q;
  modexp_pkg::exp_t exp_q;
  logic             go_q;
  logic             valid_q;
  modexp_pkg::mod_t power_q;

  modexp_pkg::mod_t one_mod;
  modexp_pkg::mod_t mul_prod, sq_prod;
  modexp_pkg::mod_t sq_b;
  logic             mul_done, sq_done;
  modexp_pkg::mod_t acc_d;
  modexp_pkg::exp_t exp_d;

  assign one_mod = (modulus_q == modexp_pkg::MOD_WIDTH'(1)) ? '0
                                                            : modexp_pkg::MOD_WIDTH'(1);
  assign sq_b    = (state_q == S_RED) ? one_mod : base_q;
  assign acc_d   = exp_q[0] ? mul_prod : acc_q;
  assign exp_d   = exp_q >> 1;

  modexp_mulmod u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go_q),
    .a_i    (acc_q),
    .b_i    (base_q),
    .m_i    (modulus_q),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  modexp_mulmod u_sq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go_q),
    .a_i    (base_q),
    .b_i    (sq_b),
    .m_i    (modulus_q),
    .done_o (sq_done),
    .prod_o (sq_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      modulus_q <= modexp_pkg::MODULUS_RESET;
      go_q      <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      go_q    <= 1'b0;
      valid_q <= 1'b0;
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_RED;
            go_q    <= 1'b1;
          end
        end
        S_RED: begin
          if (sq_done) begin
            if (exp_q == '0) begin
              state_q <= S_IDLE;
              valid_q <= 1'b1;
            end else begin
              state_q <= S_ROUND;
              go_q    <= 1'b1;
            end
          end
        end
        S_ROUND: begin
          if (sq_done) begin
            if (exp_d == '0) begin
              state_q <= S_IDLE;
              valid_q <= 1'b1;
            end else begin
              go_q <= 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          base_q <= base_i;
          exp_q  <= exponent_i;
          acc_q  <= one_mod;
        end
      end
      S_RED: begin
        if (sq_done) begin
          base_q  <= sq_prod;
          power_q <= (modulus_q == '0) ? '0 : acc_q;
        end
      end
      S_ROUND: begin
        if (sq_done) begin
          base_q  <= sq_prod;
          acc_q   <= acc_d;
          exp_q   <= exp_d;
          power_q <= (modulus_q == '0) ? '0 : acc_d;
        end
      end
      default: ;
    endcase
  end

  assign busy        = (state_q != S_IDLE);
  assign valid_o     = valid_q;
  assign power_mod_o = power_q;

  // both units launch together and run the same number of steps
  assert property (@(posedge clk_i) disable iff (!rst_ni) mul_done == sq_done)
    else $error("multiplier and squarer out of step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted command did not start work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q != S_IDLE) && !$past(valid_o))
    else $error("result beat without a command in flight");

endmodule

// ===== rtl/modexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// modexp_mulmod
// Bit-serial modular multiplier: a * b mod m, one bit of a per cycle, msb
// first, with double-and-reduce then add-and-reduce in each step.
// ----------------------------------------------------------------------------
module modexp_mulmod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  modexp_pkg::mod_t  a_i,
  input  modexp_pkg::mod_t  b_i,
  input  modexp_pkg::mod_t  m_i,
  output logic              done_o,
  output modexp_pkg::mod_t  prod_o
);

  localparam int W = modexp_pkg::MOD_WIDTH;

  logic             active_q, active_d;
  logic             done_q, done_d;
  modexp_pkg::cnt_t cnt_q, cnt_d;
  modexp_pkg::mod_t a_q, a_d;
  modexp_pkg::mod_t b_q, b_d;
  modexp_pkg::mod_t r_q, r_d;

  logic [W:0]       dbl;
  modexp_pkg::mod_t dbl_red;
  logic [W:0]       sum;
  modexp_pkg::mod_t step_r;

  always_comb begin
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, m_i}) ? W'(dbl - {1'b0, m_i}) : W'(dbl);
    sum     = {1'b0, dbl_red} + (a_q[W-1] ? {1'b0, b_q} : '0);
    step_r  = (sum >= {1'b0, m_i}) ? W'(sum - {1'b0, m_i}) : W'(sum);
  end

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    a_d      = a_q;
    b_d      = b_q;
    r_d      = r_q;
    if (go_i) begin
      active_d = 1'b1;
      cnt_d    = modexp_pkg::CNT_WIDTH'(W);
      a_d      = a_i;
      b_d      = b_i;
      r_d      = '0;
    end else if (active_q) begin
      r_d   = step_r;
      a_d   = {a_q[W-2:0], 1'b0};
      cnt_d = cnt_q - modexp_pkg::CNT_WIDTH'(1);
      if (cnt_q == modexp_pkg::CNT_WIDTH'(1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign prod_o = r_q;

endmodule
